/* rtl/gdd_pkg.sv */
// Package: payload types, constants and month table for the Gregorian day difference unit.
`default_nettype none
package gdd_pkg;

	localparam int DayW    = 5;
	localparam int MonthW  = 4;
	localparam int YearW   = 14;
	localparam int SerialW = 23;
	localparam int DistW   = 22;
	localparam int LeapW   = 13;
	localparam int DbmW    = 9;
	localparam int QuotW   = 8;
	localparam int RecipW  = 13;
	localparam int ProdW   = YearW + RecipW;

	// floor(x / 100) = (x * Recip100) >> Recip100Shift for every 14-bit x
	localparam logic [RecipW-1:0] Recip100      = 13'd5243;
	localparam int                Recip100Shift = 19;
	localparam logic [8:0]        DaysPerYear   = 9'd365;

	localparam logic [DistW-1:0] MaxDistance = {DistW{1'b1}};

	typedef logic signed [1:0] order_t;
	localparam order_t OrderEqual   = 2'sb00;
	localparam order_t OrderLater   = 2'sb01;
	localparam order_t OrderEarlier = 2'sb11;

	typedef struct packed {
		logic [DayW-1:0]   day_a;
		logic [MonthW-1:0] month_a;
		logic [YearW-1:0]  year_a;
		logic [DayW-1:0]   day_b;
		logic [MonthW-1:0] month_b;
		logic [YearW-1:0]  year_b;
	} in_beat_t;

	typedef struct packed {
		order_t           order;
		logic [DistW-1:0] day_distance;
	} out_beat_t;

	function automatic logic [DbmW-1:0] days_before_month(input logic [MonthW-1:0] month);
		logic [DbmW-1:0] d;
		unique case (month)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			4'd13:   d = 9'd365;
			4'd14:   d = 9'd396;
			default: d = 9'd427;
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

/* rtl/gdd_if.sv */
// Interfaces: valid/ready channels for date pair beats and result beats.
`default_nettype none
interface gdd_in_if;
	import gdd_pkg::*;
	logic     valid;
	logic     ready;
	in_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface gdd_out_if;
	import gdd_pkg::*;
	logic      valid;
	logic      ready;
	out_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/gdd_serial.sv */
// Three-stage pipeline that turns one Gregorian date into its serial day number.
`default_nettype none
module gdd_serial (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [gdd_pkg::DayW-1:0]    day,
	input  wire logic [gdd_pkg::MonthW-1:0]  month,
	input  wire logic [gdd_pkg::YearW-1:0]   year,
	output logic      [gdd_pkg::SerialW-1:0] serial
);
	import gdd_pkg::*;

	// stage 1: products
	logic [DayW-1:0]    day_s1;
	logic [MonthW-1:0]  month_s1;
	logic [YearW-1:0]   year_s1;
	logic [YearW-1:0]   prev_s1;
	logic               nonzero_s1;
	logic [ProdW-1:0]   prod_y_s1;
	logic [ProdW-1:0]   prod_p_s1;
	logic [SerialW-1:0] n365_s1;

	// stage 2: quotients, remainder, leap-day count
	logic [DayW-1:0]    day_s2;
	logic [MonthW-1:0]  month_s2;
	logic [SerialW-1:0] n365_s2;
	logic               leap_s2;
	logic [LeapW-1:0]   lcount_s2;

	logic [YearW-1:0] prev;
	logic [QuotW-1:0] q_y;
	logic [QuotW-1:0] q_p;
	logic [YearW-1:0] rem_y;
	logic             leap;
	logic [LeapW-1:0] lcount;

	assign prev = year - YearW'(1);

	always_ff @(posedge clk) begin
		if (en) begin
			day_s1     <= day;
			month_s1   <= month;
			year_s1    <= year;
			prev_s1    <= prev;
			nonzero_s1 <= (year != '0);
			prod_y_s1  <= ProdW'(year) * ProdW'(Recip100);
			prod_p_s1  <= ProdW'(prev) * ProdW'(Recip100);
			n365_s1    <= SerialW'(year) * SerialW'(DaysPerYear);
		end
	end

	assign q_y   = QuotW'(prod_y_s1 >> Recip100Shift);
	assign q_p   = QuotW'(prod_p_s1 >> Recip100Shift);
	assign rem_y = year_s1 - YearW'(YearW'(q_y) * YearW'(100));
	assign leap  = (rem_y == '0) ? (q_y[1:0] == 2'd0) : (year_s1[1:0] == 2'd0);
	assign lcount = nonzero_s1
		? LeapW'(LeapW'(prev_s1 >> 2) - LeapW'(q_p) + LeapW'(q_p >> 2) + LeapW'(1))
		: '0;

	always_ff @(posedge clk) begin
		if (en) begin
			day_s2    <= day_s1;
			month_s2  <= month_s1;
			n365_s2   <= n365_s1;
			leap_s2   <= leap;
			lcount_s2 <= lcount;
		end
	end

	// stage 3: sum
	always_ff @(posedge clk) begin
		if (en) begin
			serial <= n365_s2 + SerialW'(lcount_s2)
				+ SerialW'(days_before_month(month_s2))
				+ SerialW'(leap_s2 && (month_s2 > MonthW'(2)))
				+ SerialW'(day_s2);
		end
	end

endmodule
`default_nettype wire

/* rtl/gregorian_day_difference_unit.sv */
// Top level: order and day distance between two Gregorian dates.
// Accepts one date pair per cycle while the output side keeps up, and returns one result per
// pair, in order. The four register stages are the
// reciprocal multiplies for the divisions by 100, the leap-day count, the serial-day sum
// and the final subtract with saturation at the largest 22-bit value; the last stage is
// the output register. The whole pipeline advances when the output register is empty or
// its beat is taken, so din.ready follows dout.ready in the same cycle.
`default_nettype none
module gregorian_day_difference_unit (
	input wire logic clk,
	input wire logic arst_n,
	gdd_in_if.sink   din,
	gdd_out_if.source dout
);
	import gdd_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;
	order_t ord_in, ord_s1, ord_s2, ord_s3, ord_s4;
	logic [SerialW-1:0] serial_a, serial_b, diff;
	logic [DistW-1:0]   dist_s4;

	assign en        = !v_s4 || dout.ready;
	assign din.ready = en;

	always_comb begin
		priority if (din.data.year_a != din.data.year_b) begin
			ord_in = (din.data.year_a > din.data.year_b) ? OrderLater : OrderEarlier;
		end else if (din.data.month_a != din.data.month_b) begin
			ord_in = (din.data.month_a > din.data.month_b) ? OrderLater : OrderEarlier;
		end else if (din.data.day_a != din.data.day_b) begin
			ord_in = (din.data.day_a > din.data.day_b) ? OrderLater : OrderEarlier;
		end else begin
			ord_in = OrderEqual;
		end
	end

	gdd_serial u_serial_a (
		.clk    (clk),
		.en     (en),
		.day    (din.data.day_a),
		.month  (din.data.month_a),
		.year   (din.data.year_a),
		.serial (serial_a)
	);

	gdd_serial u_serial_b (
		.clk    (clk),
		.en     (en),
		.day    (din.data.day_b),
		.month  (din.data.month_b),
		.year   (din.data.year_b),
		.serial (serial_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= din.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign diff = (serial_a > serial_b) ? (serial_a - serial_b) : (serial_b - serial_a);

	always_ff @(posedge clk) begin
		if (en) begin
			ord_s1  <= ord_in;
			ord_s2  <= ord_s1;
			ord_s3  <= ord_s2;
			ord_s4  <= ord_s3;
			dist_s4 <= diff[SerialW-1] ? MaxDistance : diff[DistW-1:0];
		end
	end

	assign dout.valid             = v_s4;
	assign dout.data.order        = ord_s4;
	assign dout.data.day_distance = dist_s4;

endmodule
`default_nettype wire
